// ===== rtl/core/ppd_pkg.sv =====
// shared types, constants and the arctangent table for the polyline distance block
// no dependencies
package ppd_pkg;

  localparam int COORD_BITS       = 32;
  localparam int FRAC_BITS        = 16;
  localparam int BULGE_BITS       = FRAC_BITS + 8;
  localparam int DIST_BITS        = COORD_BITS + 1;
  localparam int ANGLE_ITERATIONS = 24;
  localparam int DW               = 64;
  localparam int ZW               = 34;
  localparam int IT_BITS          = 5;
  localparam int SH_BITS          = 6;
  localparam int CAP_BITS         = 58;

  localparam logic [31:0]         CORDIC_GAIN  = 32'h9B74EDA8;
  localparam logic [DW-1:0]       NORM_LIMIT   = 64'd1 << 58;
  localparam logic [DW-1:0]       COARSE_LIMIT = 64'd1 << 50;
  localparam logic [CAP_BITS-1:0] FAR_CAP      = 58'd1 << 57;

  typedef enum logic {
    CORDIC_VEC,
    CORDIC_ROT
  } cordic_mode_e;

  typedef struct packed {
    cordic_mode_e       mode;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [31:0]        turn;
  } cordic_req_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [31:0]        ang;
  } cordic_rsp_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
  } muldiv_req_t;

  function automatic logic [31:0] atan_bam(input logic [IT_BITS-1:0] k);
    logic [31:0] r;
    case (k)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/ppd_cordic.sv =====
// iterative cordic: vectoring and rotation with normalise and gain removal
// depends on ppd_pkg
module ppd_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ppd_pkg::cordic_req_t req_i,
  output logic                ready_o,
  output logic                done_o,
  output ppd_pkg::cordic_rsp_t rsp_o
);
  import ppd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_PRE, S_ITER, S_MUL0, S_MUL1, S_RND, S_DONE
  } state_e;

  localparam logic [IT_BITS-1:0] IT_LAST = IT_BITS'(ANGLE_ITERATIONS - 1);

  state_e                state_q, state_d;
  cordic_mode_e          mode_q, mode_d;
  logic signed [DW-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]  z_q, z_d;
  logic [SH_BITS-1:0]    s_q, s_d;
  logic [IT_BITS-1:0]    i_q, i_d;
  logic                  c_q, c_d;
  logic [DW-1:0]         lo_q, lo_d, acc_q, acc_d;

  logic [DW-1:0]         mx, my, mag, cmag, prod, rnd, rnd_s;
  logic signed [DW-1:0]  cv, sx, sy;
  logic [31:0]           mul_a;
  logic [DW:0]           lo_rnd;
  logic signed [ZW-1:0]  at;
  logic                  up;

  always_comb begin
    mx     = x_q[DW-1] ? DW'(-x_q) : DW'(x_q);
    my     = y_q[DW-1] ? DW'(-y_q) : DW'(y_q);
    mag    = mx | my;
    cv     = c_q ? y_q : x_q;
    cmag   = cv[DW-1] ? DW'(-cv) : DW'(cv);
    mul_a  = (state_q == S_MUL1) ? cmag[63:32] : cmag[31:0];
    prod   = DW'(mul_a) * DW'(CORDIC_GAIN);
    lo_rnd = {1'b0, lo_q} + (65'd1 << 31);
    sx     = x_q >>> i_q;
    sy     = y_q >>> i_q;
    at     = ZW'(atan_bam(i_q));
    up     = (mode_q == CORDIC_VEC) ? ~y_q[DW-1] : z_q[ZW-1];
    if (s_q == '0) begin
      rnd = acc_q;
    end else begin
      rnd = (acc_q + (64'd1 << (s_q - SH_BITS'(1)))) >> s_q;
    end
    rnd_s = cv[DW-1] ? DW'(-rnd) : rnd;
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    s_d     = s_q;
    i_d     = i_q;
    c_d     = c_q;
    lo_d    = lo_q;
    acc_d   = acc_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mode_d  = req_i.mode;
          x_d     = req_i.x;
          y_d     = req_i.y;
          z_d     = ZW'($signed(req_i.turn));
          s_d     = '0;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (mag == '0) begin
          z_d     = '0;
          state_d = S_DONE;
        end else if (mag >= NORM_LIMIT) begin
          state_d = S_PRE;
        end else if (mag < COARSE_LIMIT) begin
          x_d = x_q <<< 8;
          y_d = y_q <<< 8;
          s_d = s_q + SH_BITS'(8);
        end else begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
          s_d = s_q + SH_BITS'(1);
        end
      end
      S_PRE: begin
        i_d     = '0;
        state_d = S_ITER;
        if (mode_q == CORDIC_VEC) begin
          if (x_q[DW-1]) begin
            x_d = -x_q;
            y_d = -y_q;
            z_d = ZW'(34'sh0_8000_0000);
          end else begin
            z_d = '0;
          end
        end else if (z_q > ZW'(34'sh0_4000_0000)) begin
          x_d = -x_q;
          y_d = -y_q;
          z_d = z_q - ZW'(34'sh0_8000_0000);
        end else if (z_q < -ZW'(34'sh0_4000_0000)) begin
          x_d = -x_q;
          y_d = -y_q;
          z_d = z_q + ZW'(34'sh0_8000_0000);
        end
      end
      S_ITER: begin
        if (up) begin
          x_d = x_q + sy;
          y_d = y_q - sx;
          z_d = z_q + at;
        end else begin
          x_d = x_q - sy;
          y_d = y_q + sx;
          z_d = z_q - at;
        end
        i_d = i_q + IT_BITS'(1);
        if (i_q == IT_LAST) begin
          c_d     = 1'b0;
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        lo_d    = prod;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        acc_d   = prod + DW'(lo_rnd >> 32);
        state_d = S_RND;
      end
      S_RND: begin
        if (c_q) begin
          y_d = $signed(rnd_s);
        end else begin
          x_d = $signed(rnd_s);
        end
        if (mode_q == CORDIC_ROT && !c_q) begin
          c_d     = 1'b1;
          state_d = S_MUL0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    s_q    <= s_d;
    i_q    <= i_d;
    c_q    <= c_d;
    lo_q   <= lo_d;
    acc_q  <= acc_d;
  end

  assign ready_o   = (state_q == S_IDLE);
  assign done_o    = (state_q == S_DONE);
  assign rsp_o.x   = x_q;
  assign rsp_o.y   = y_q;
  assign rsp_o.ang = z_q[31:0];

endmodule

// ===== rtl/core/ppd_muldiv.sv =====
// bit-serial multiply then restoring divide, round to nearest, capped result
// depends on ppd_pkg
module ppd_muldiv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ppd_pkg::muldiv_req_t  req_i,
  output logic                  ready_o,
  output logic                  done_o,
  output logic [ppd_pkg::CAP_BITS-1:0] res_o
);
  import ppd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ADD, S_CHK, S_DIV, S_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [127:0]  a_q, a_d, prod_q, prod_d;
  logic [63:0]   b_q, b_d, d_q, d_d, lo_q, lo_d, q_q, q_d;
  logic [64:0]   rem_q, rem_d, rs;
  logic [5:0]    cnt_q, cnt_d;
  logic          ge;

  always_comb begin
    rs = {rem_q[63:0], lo_q[63]};
    ge = (rs >= {1'b0, d_q});
  end

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    d_d     = d_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    q_d     = q_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          a_d     = {64'd0, req_i.a};
          b_d     = req_i.b;
          d_d     = req_i.d;
          prod_d  = '0;
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (b_q[0]) begin
          prod_d = prod_q + a_q;
        end
        a_d   = a_q << 1;
        b_d   = b_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        prod_d  = prod_q + {64'd0, d_q >> 1};
        state_d = S_CHK;
      end
      S_CHK: begin
        if (prod_q[127:64] >= d_q) begin
          q_d     = 64'(FAR_CAP);
          state_d = S_DONE;
        end else begin
          rem_d   = {1'b0, prod_q[127:64]};
          lo_d    = prod_q[63:0];
          q_d     = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = ge ? rs - {1'b0, d_q} : rs;
        q_d   = {q_q[62:0], ge};
        lo_d  = lo_q << 1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    d_q    <= d_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    q_q    <= q_d;
    cnt_q  <= cnt_d;
  end

  assign ready_o = (state_q == S_IDLE);
  assign done_o  = (state_q == S_DONE);
  assign res_o   = (q_q > 64'(FAR_CAP)) ? FAR_CAP : q_q[CAP_BITS-1:0];

endmodule

// ===== rtl/core/polyline_point_distance.sv =====
// Distance from a query point to a polyline with bulge arcs, one segment per
// input transaction. The time a segment takes is set by the shared cordic unit
// (up to seven runs of 24 iterations each) and the bit-serial multiply-divide
// unit (two runs, for the arc radius and centre offset). tready is low while a
// segment is being worked. The running minimum is sent on the segment marked
// by tlast and then returns to all ones; a finished result waits in the output
// register while the next segment is taken.
// top level; depends on ppd_pkg, ppd_cordic and ppd_muldiv
module polyline_point_distance (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // query_x, query_y, start_x, start_y, end_x, end_y, bulge
  input  logic [215:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // min_distance, zero padded
  output logic [39:0]  m_axis_tdata
);
  import ppd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DA, S_DA_W, S_DB, S_DB_W, S_LEN, S_LEN_W, S_ROT, S_ROT_W, S_LINE,
    S_KSQ, S_R2, S_R2_W, S_HM, S_HM_W, S_MD, S_MD_W, S_AA, S_AA_W, S_HALF,
    S_HALF_W, S_ARC, S_FIN
  } state_e;

  localparam logic [48:0] ONE = 49'd1 << (2 * FRAC_BITS);

  state_e                      state_q;
  logic signed [COORD_BITS:0]  pax_q, pay_q, pbx_q, pby_q, cx_q, cy_q;
  logic signed [BULGE_BITS-1:0] k_q;
  logic                        last_q;
  logic [DW-1:0]               da_q, db_q, len_q, md_q, dist_q;
  logic [31:0]                 th_q, angd_q, anga_q, half_q;
  logic signed [DW-1:0]        u_q, v_q;
  logic [47:0]                 ksq_q;
  logic [CAP_BITS-1:0]         r2_q, hm_q;
  logic [DIST_BITS-1:0]        run_q, out_data_q;
  logic                        out_valid_q;

  cordic_req_t          creq;
  cordic_rsp_t          crsp;
  muldiv_req_t          mreq;
  logic                 cordic_start, cordic_ready, cordic_done;
  logic                 mdiv_start, mdiv_ready, mdiv_done;
  logic [CAP_BITS-1:0]  mdiv_res;

  logic [BULGE_BITS-1:0] kabs;
  logic [48:0]           ksum, kdiff;
  logic                  kpos, hpos;
  logic signed [DW-1:0]  h2, absv;
  logic [33:0]           sweep;
  logic [31:0]           from, rel;
  logic [DW-1:0]         arcd, nearer;
  logic [DIST_BITS-1:0]  dclamp, newmin;
  logic                  out_load, in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    kabs   = k_q[BULGE_BITS-1] ? BULGE_BITS'(-k_q) : BULGE_BITS'(k_q);
    kpos   = ~k_q[BULGE_BITS-1] && (k_q != '0);
    ksum   = ONE + 49'(ksq_q);
    kdiff  = (ONE > 49'(ksq_q)) ? ONE - 49'(ksq_q) : 49'(ksq_q) - ONE;
    hpos   = ((ONE > 49'(ksq_q)) == kpos);
    h2     = hpos ? $signed(DW'(hm_q)) : -$signed(DW'(hm_q));
    absv   = v_q[DW-1] ? -v_q : v_q;
    sweep  = {half_q, 2'b00};
    from   = kpos ? anga_q : anga_q - sweep[31:0];
    rel    = angd_q - from;
    arcd   = (md_q > DW'(r2_q)) ? md_q - DW'(r2_q) : DW'(r2_q) - md_q;
    nearer = (da_q < db_q) ? da_q : db_q;
    dclamp = (dist_q > DW'({DIST_BITS{1'b1}})) ? '1 : dist_q[DIST_BITS-1:0];
    newmin = (dclamp < run_q) ? dclamp : run_q;
  end

  always_comb begin
    creq.mode = CORDIC_VEC;
    creq.x    = '0;
    creq.y    = '0;
    creq.turn = '0;
    case (state_q)
      S_DA: begin
        creq.x = DW'(pax_q);
        creq.y = DW'(pay_q);
      end
      S_DB: begin
        creq.x = DW'(pbx_q);
        creq.y = DW'(pby_q);
      end
      S_LEN: begin
        creq.x = DW'(cx_q);
        creq.y = DW'(cy_q);
      end
      S_ROT: begin
        creq.mode = CORDIC_ROT;
        creq.x    = DW'(pax_q);
        creq.y    = DW'(pay_q);
        creq.turn = 32'd0 - th_q;
      end
      S_MD: begin
        creq.x = (u_q <<< 1) - $signed(len_q);
        creq.y = (v_q <<< 1) - h2;
      end
      S_AA: begin
        creq.x = -$signed(len_q);
        creq.y = -h2;
      end
      S_HALF: begin
        creq.x = $signed(DW'(1) << FRAC_BITS);
        creq.y = $signed(DW'(kabs));
      end
      default: creq.mode = CORDIC_VEC;
    endcase
  end

  assign cordic_start = (state_q == S_DA) || (state_q == S_DB) || (state_q == S_LEN) ||
                        (state_q == S_ROT) || (state_q == S_MD) || (state_q == S_AA) ||
                        (state_q == S_HALF);
  assign mdiv_start   = (state_q == S_R2) || (state_q == S_HM);
  assign mreq.a       = len_q;
  assign mreq.b       = (state_q == S_R2) ? DW'(ksum) : DW'(kdiff);
  assign mreq.d       = DW'(kabs) << (FRAC_BITS + 1);

  ppd_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .req_i   (creq),
    .ready_o (cordic_ready),
    .done_o  (cordic_done),
    .rsp_o   (crsp)
  );

  ppd_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mdiv_start),
    .req_i   (mreq),
    .ready_o (mdiv_ready),
    .done_o  (mdiv_done),
    .res_o   (mdiv_res)
  );

  assign out_load = (state_q == S_FIN) && last_q && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE:   if (in_accept) state_q <= S_DA;
        S_DA:     state_q <= S_DA_W;
        S_DA_W:   if (cordic_done) state_q <= S_DB;
        S_DB:     state_q <= S_DB_W;
        S_DB_W: begin
          if (cordic_done) begin
            state_q <= (cx_q == '0 && cy_q == '0) ? S_FIN : S_LEN;
          end
        end
        S_LEN:    state_q <= S_LEN_W;
        S_LEN_W:  if (cordic_done) state_q <= S_ROT;
        S_ROT:    state_q <= S_ROT_W;
        S_ROT_W:  if (cordic_done) state_q <= S_LINE;
        S_LINE:   state_q <= (k_q == '0) ? S_FIN : S_KSQ;
        S_KSQ:    state_q <= S_R2;
        S_R2:     state_q <= S_R2_W;
        S_R2_W:   if (mdiv_done) state_q <= S_HM;
        S_HM:     state_q <= S_HM_W;
        S_HM_W:   if (mdiv_done) state_q <= S_MD;
        S_MD:     state_q <= S_MD_W;
        S_MD_W:   if (cordic_done) state_q <= S_AA;
        S_AA:     state_q <= S_AA_W;
        S_AA_W:   if (cordic_done) state_q <= S_HALF;
        S_HALF:   state_q <= S_HALF_W;
        S_HALF_W: if (cordic_done) state_q <= S_ARC;
        S_ARC:    state_q <= S_FIN;
        S_FIN: begin
          if (!last_q) begin
            run_q   <= newmin;
            state_q <= S_IDLE;
          end else if (out_load) begin
            run_q   <= '1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pax_q  <= (COORD_BITS+1)'($signed(s_axis_tdata[31:0])) -
                (COORD_BITS+1)'($signed(s_axis_tdata[95:64]));
      pay_q  <= (COORD_BITS+1)'($signed(s_axis_tdata[63:32])) -
                (COORD_BITS+1)'($signed(s_axis_tdata[127:96]));
      pbx_q  <= (COORD_BITS+1)'($signed(s_axis_tdata[31:0])) -
                (COORD_BITS+1)'($signed(s_axis_tdata[159:128]));
      pby_q  <= (COORD_BITS+1)'($signed(s_axis_tdata[63:32])) -
                (COORD_BITS+1)'($signed(s_axis_tdata[191:160]));
      cx_q   <= (COORD_BITS+1)'($signed(s_axis_tdata[159:128])) -
                (COORD_BITS+1)'($signed(s_axis_tdata[95:64]));
      cy_q   <= (COORD_BITS+1)'($signed(s_axis_tdata[191:160])) -
                (COORD_BITS+1)'($signed(s_axis_tdata[127:96]));
      k_q    <= $signed(s_axis_tdata[215:192]);
      last_q <= s_axis_tlast;
    end
    case (state_q)
      S_DA_W:   if (cordic_done) da_q <= $unsigned(crsp.x);
      S_DB_W: begin
        if (cordic_done) begin
          db_q   <= $unsigned(crsp.x);
          dist_q <= da_q;
        end
      end
      S_LEN_W: begin
        if (cordic_done) begin
          len_q <= $unsigned(crsp.x);
          th_q  <= crsp.ang;
        end
      end
      S_ROT_W: begin
        if (cordic_done) begin
          u_q <= crsp.x;
          v_q <= crsp.y;
        end
      end
      S_LINE: begin
        if (u_q <= 0) begin
          dist_q <= da_q;
        end else if ($unsigned(u_q) >= len_q) begin
          dist_q <= db_q;
        end else begin
          dist_q <= $unsigned(absv);
        end
      end
      S_KSQ:    ksq_q <= 48'(kabs) * 48'(kabs);
      S_R2_W:   if (mdiv_done) r2_q <= mdiv_res;
      S_HM_W:   if (mdiv_done) hm_q <= mdiv_res;
      S_MD_W: begin
        if (cordic_done) begin
          md_q   <= $unsigned(crsp.x);
          angd_q <= crsp.ang;
        end
      end
      S_AA_W:   if (cordic_done) anga_q <= crsp.ang;
      S_HALF_W: if (cordic_done) half_q <= crsp.ang;
      S_ARC:    dist_q <= ({2'b00, rel} <= sweep) ? (arcd + DW'(1)) >> 1 : nearer;
      default:  dist_q <= dist_q;
    endcase
    if (out_load) begin
      out_data_q <= newmin;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_data_q};

`ifndef SYNTH
  a_cordic_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_start |-> cordic_ready)
    else $error("cordic started while busy");
  a_mdiv_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdiv_start |-> mdiv_ready)
    else $error("divider started while busy");
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN && last_q))
    else $error("result shown without a last segment");
  a_run_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (run_q == '1))
    else $error("running minimum not cleared after report");
`endif

endmodule

// ===== test/tb.sv =====
// self-checking testbench for polyline_point_distance: segments with and without bulge arcs
// are streamed in, the running minimum is predicted in integer arithmetic and compared
// depends on ppd_pkg and the polyline_point_distance rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppd_pkg::*;

  localparam int                     N_ITEMS   = 650;
  localparam longint                 LIMIT     = 3000000;
  localparam longint unsigned        DMAX      = (64'd1 << DIST_BITS) - 64'd1;
  localparam longint unsigned        GAIN      = 64'h9B74EDA8;
  localparam longint unsigned        ARC_LIMIT = 64'd1 << 57;

  localparam bit [31:0] TURN_STEP [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    logic signed [31:0] qx, qy, sx, sy, ex, ey;
    logic signed [23:0] bulge;
    bit                 last;
    bit                 drain;
  } segment_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // query_x, query_y, start_x, start_y, end_x, end_y, bulge
  logic [215:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // min_distance, zero padded
  logic [39:0]  m_axis_tdata;

  segment_t              seg_q[$];
  segment_t              cur_seg;
  longint unsigned       min_dist_q[$];
  longint unsigned       run_min = DMAX;
  longint unsigned       got_min;
  longint unsigned       seg_d;
  int                    seg_cnt, arc_cnt, result_cnt, err_cnt, sat_cnt;
  int                    hold_left;
  bit                    hold_done, offering;
  longint                cycle_cnt;

  polyline_point_distance u_top (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned mul_div_round(longint unsigned a, longint unsigned b,
                                                    longint unsigned d, longint unsigned cap);
    bit [127:0] p;
    bit [127:0] q;
    p = {64'd0, a} * {64'd0, b} + {64'd0, d >> 1};
    if (p[127:64] >= d) return cap;
    q = p / {64'd0, d};
    return (q[63:0] > cap) ? cap : q[63:0];
  endfunction

  function automatic longint gain_correct(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = mul_div_round(m, GAIN, 64'd1 << 32, '1);
    if (s > 0) m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic int norm_shift(inout longint x, inout longint y);
    longint unsigned m;
    int s;
    m = ((x < 0) ? -x : x) | ((y < 0) ? -y : y);
    s = 0;
    if (m == 0) return 0;
    while (m < (64'd1 << 58)) begin
      m = m << 1;
      s++;
    end
    x = x <<< s;
    y = y <<< s;
    return s;
  endfunction

  function automatic longint unsigned vec_mag(longint x, longint y, output bit [31:0] ang);
    bit [31:0] z;
    int s;
    longint dx, dy;
    z = '0;
    ang = '0;
    if (x == 0 && y == 0) return 0;
    s = norm_shift(x, y);
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += TURN_STEP[i];
      end else begin
        x -= dx; y += dy; z -= TURN_STEP[i];
      end
    end
    ang = z;
    return longint'(gain_correct(x, s));
  endfunction

  function automatic void rotate_by(longint x, longint y, bit [31:0] turn,
                                    output longint ox, output longint oy);
    longint z, dx, dy;
    int s;
    z = turn[31] ? longint'({32'd0, turn}) - 64'sh100000000 : longint'({32'd0, turn});
    s = norm_shift(x, y);
    if (z > 64'sh40000000) begin
      x = -x; y = -y; z -= 64'sh80000000;
    end else if (z < -64'sh40000000) begin
      x = -x; y = -y; z += 64'sh80000000;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= TURN_STEP[i];
      end else begin
        x += dx; y -= dy; z += TURN_STEP[i];
      end
    end
    ox = gain_correct(x, s);
    oy = gain_correct(y, s);
  endfunction

  function automatic longint unsigned segment_distance(segment_t g, output bit is_arc);
    longint px, py, ax, ay, bx, by, k, cx, cy, u, v, lh, h2;
    longint unsigned da, db, len, kabs, one, ksq, den, r2, hmag, md, sweep, diff;
    bit [31:0] ang, th, ang_d, ang_a, half, from, rel;
    px = g.qx; py = g.qy; ax = g.sx; ay = g.sy; bx = g.ex; by = g.ey; k = g.bulge;
    is_arc = 1'b0;
    cx = bx - ax;
    cy = by - ay;
    da = vec_mag(px - ax, py - ay, ang);
    db = vec_mag(px - bx, py - by, ang);
    if (cx == 0 && cy == 0) return da;
    len = vec_mag(cx, cy, th);
    rotate_by(px - ax, py - ay, 32'd0 - th, u, v);
    if (k == 0) begin
      if (u <= 0) return da;
      if ($unsigned(u) >= len) return db;
      return (v < 0) ? -v : v;
    end
    is_arc = 1'b1;
    kabs = (k < 0) ? -k : k;
    one = 64'd1 << (2 * FRAC_BITS);
    ksq = kabs * kabs;
    den = kabs << (FRAC_BITS + 1);
    r2 = mul_div_round(len, one + ksq, den, ARC_LIMIT);
    hmag = mul_div_round(len, (one > ksq) ? one - ksq : ksq - one, den, ARC_LIMIT);
    h2 = ((one > ksq) == (k > 0)) ? longint'(hmag) : -longint'(hmag);
    lh = longint'(len);
    md = vec_mag(2 * u - lh, 2 * v - h2, ang_d);
    void'(vec_mag(-lh, -h2, ang_a));
    void'(vec_mag(64'd1 << FRAC_BITS, longint'(kabs), half));
    sweep = {32'd0, half} << 2;
    from = (k > 0) ? ang_a : ang_a - sweep[31:0];
    rel = ang_d - from;
    if ({32'd0, rel} <= sweep) begin
      diff = (md > r2) ? md - r2 : r2 - md;
      return (diff + 1) >> 1;
    end
    return (da < db) ? da : db;
  endfunction

  function automatic void predict_segment(segment_t g);
    bit arc;
    seg_d = segment_distance(g, arc);
    seg_cnt++;
    if (arc) arc_cnt++;
    if (seg_d > DMAX) begin
      seg_d = DMAX;
      sat_cnt++;
    end
    if (seg_d < run_min) run_min = seg_d;
    if (g.last) begin
      min_dist_q.insert(min_dist_q.size(), run_min);
      run_min = DMAX;
    end
  endfunction

  function automatic void queue_seg(segment_t g);
    seg_q.insert(seg_q.size(), g);
  endfunction

  function automatic int send_idle_pct();
    if (seg_cnt < N_ITEMS / 3) return 15;
    if (seg_cnt < 2 * N_ITEMS / 3) return 45;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (seg_cnt < N_ITEMS / 3) return 45;
    if (seg_cnt < 2 * N_ITEMS / 3) return 15;
    return 0;
  endfunction

  function automatic logic signed [31:0] rand_span(int bits);
    logic signed [31:0] r;
    r = $urandom();
    if (bits >= 32) return r;
    return r >>> (32 - bits);
  endfunction

  function automatic logic signed [23:0] rand_bulge();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return '0;
    if (pick < 70) return 24'(rand_span(18));
    if (pick < 80) return 24'(int'($urandom_range(1, 16)) * ($urandom_range(1) ? 1 : -1));
    return 24'($urandom());
  endfunction

  function automatic segment_t mk_seg(logic signed [31:0] qx, qy, sx, sy, ex, ey,
                                      logic signed [23:0] b, bit last);
    segment_t g;
    g.qx = qx; g.qy = qy; g.sx = sx; g.sy = sy; g.ex = ex; g.ey = ey;
    g.bulge = b; g.last = last; g.drain = 1'b0;
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offering = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_segment(cur_seg);
        offering = 1'b0;
      end
      if (!offering) begin
        if (seg_q.size() > 0 && $urandom_range(99) >= send_idle_pct() &&
            !(seg_q[0].drain && min_dist_q.size() > 0)) begin
          cur_seg = seg_q.pop_front();
          s_axis_tdata <= {cur_seg.bulge, cur_seg.ey, cur_seg.ex, cur_seg.sy, cur_seg.sx,
                           cur_seg.qy, cur_seg.qx};
          s_axis_tlast <= cur_seg.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_min = {31'd0, m_axis_tdata[DIST_BITS-1:0]};
        result_cnt++;
        if (min_dist_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result transaction: %0d", got_min);
        end else if (min_dist_q[0] != got_min) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("min_distance mismatch: expected %0d actual %0d", min_dist_q[0], got_min);
          void'(min_dist_q.pop_front());
        end else begin
          void'(min_dist_q.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && seg_cnt >= 200) begin
        hold_done = 1'b1;
        hold_left = 4000;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int n, plen, bits;
    logic signed [31:0] qx, qy, vx, vy, nx, ny;
    segment_t g;
    // lone vertex, zero chord with bulge, straight cases
    queue_seg(mk_seg(32'sh10000, 32'sh20000, 0, 0, 0, 0, 0, 1));
    queue_seg(mk_seg(32'sh30000, -32'sh10000, 32'sh10000, 32'sh10000,
                     32'sh10000, 32'sh10000, 24'sh010000, 1));
    queue_seg(mk_seg(32'sh50000, 32'sh30000, 0, 0, 32'sha0000, 0, 0, 0));
    queue_seg(mk_seg(-32'sh50000, 32'sh30000, 0, 0, 32'sha0000, 0, 0, 0));
    queue_seg(mk_seg(32'sh100000, 32'sh30000, 0, 0, 32'sha0000, 0, 0, 1));
    // semicircles both ways, point at the centre, sweep ends
    queue_seg(mk_seg(32'sh50000, 32'sh0, 0, 0, 32'sha0000, 0, 24'sh010000, 1));
    queue_seg(mk_seg(32'sh50000, 32'sh80000, 0, 0, 32'sha0000, 0, -24'sh010000, 1));
    queue_seg(mk_seg(0, 0, 0, 0, 32'sha0000, 0, 24'sh008000, 1));
    queue_seg(mk_seg(32'sha0000, 0, 0, 0, 32'sha0000, 0, 24'sh008000, 1));
    // far centre, extreme bulges
    queue_seg(mk_seg(32'sh0, 32'sh10000, -32'sh40000000, 0, 32'sh40000000, 0,
                     24'sh000001, 1));
    queue_seg(mk_seg(32'sh0, 32'sh10000, 0, 0, 32'sh7fff0000, 0, -24'sh000001, 1));
    queue_seg(mk_seg(32'sh20000, 32'sh20000, 0, 0, 32'sh40000, 0, 24'sh7fffff, 1));
    queue_seg(mk_seg(32'sh20000, -32'sh20000, 0, 0, 32'sh40000, 0, -24'sh800000, 1));
    // coordinate extremes and a saturated distance
    queue_seg(mk_seg(32'sh7fffffff, 32'sh7fffffff, -32'sh80000000, -32'sh80000000,
                     -32'sh80000000, -32'sh80000000, 0, 1));
    queue_seg(mk_seg(-32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, -32'sh80000000,
                     32'sh7fffffff, -32'sh80000000, 24'sh7fffff, 1));
    queue_seg(mk_seg(-32'sh80000000, -32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                     -32'sh80000000, 32'sh7fffffff, -24'sh800000, 0));
    queue_seg(mk_seg(32'sh7fffffff, -32'sh80000000, -32'sh80000000, 32'sh7fffffff,
                     32'sh7fffffff, 32'sh7fffffff, 24'sh123456, 1));
    // random polylines of chained vertices sharing one query point; some segments are replaced by fully random ones
    n = seg_q.size();
    while (n < N_ITEMS) begin
      plen = $urandom_range(1, 5);
      case ($urandom_range(3))
        0: bits = 14;
        1: bits = 22;
        2: bits = 28;
        default: bits = 32;
      endcase
      vx = rand_span(bits); vy = rand_span(bits);
      qx = vx + rand_span(bits); qy = vy + rand_span(bits);
      for (int i = 0; i < plen; i++) begin
        if ($urandom_range(9) == 0) begin
          nx = vx; ny = vy;
        end else begin
          nx = vx + rand_span(bits); ny = vy + rand_span(bits);
        end
        g = mk_seg(qx, qy, vx, vy, nx, ny, rand_bulge(), i == plen - 1);
        if ($urandom_range(19) == 0) g = mk_seg($urandom(), $urandom(), $urandom(),
                                                 $urandom(), $urandom(), $urandom(),
                                                 24'($urandom()), i == plen - 1);
        g.drain = (n == 400);
        queue_seg(g);
        vx = nx; vy = ny;
        n++;
      end
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (seg_q.size() == 0 && !s_axis_tvalid);
    wait (min_dist_q.size() == 0);
    repeat (800) @(posedge clk_i);
    $display("%0d segments (%0d arcs, %0d saturated), %0d minima checked, %0d errors",
             seg_cnt, arc_cnt, sat_cnt, result_cnt, err_cnt);
    $display("stalls on both sides, one long output hold-off and one drained pause");
    if (err_cnt == 0 && min_dist_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/ppd_pkg.sv
rtl/core/ppd_cordic.sv
rtl/core/ppd_muldiv.sv
rtl/core/polyline_point_distance.sv
test/tb.sv
